>>> rtl/core/rvdec_pkg.sv
`timescale 1ns / 1ps

package rvdec_pkg;

    typedef logic [6:0] opcode_t;
    typedef logic [5:0] mnem_t;
    typedef logic [1:0] alu_class_t;
    typedef logic [8:0] ctrl_flags_t;

    localparam opcode_t OPC_LOAD    = 7'b0000011;
    localparam opcode_t OPC_LOADFP  = 7'b0000111;
    localparam opcode_t OPC_OPIMM   = 7'b0010011;
    localparam opcode_t OPC_AUIPC   = 7'b0010111;
    localparam opcode_t OPC_STORE   = 7'b0100011;
    localparam opcode_t OPC_STOREFP = 7'b0100111;
    localparam opcode_t OPC_OP      = 7'b0110011;
    localparam opcode_t OPC_LUI     = 7'b0110111;
    localparam opcode_t OPC_BRANCH  = 7'b1100011;
    localparam opcode_t OPC_JALR    = 7'b1100111;
    localparam opcode_t OPC_JAL     = 7'b1101111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    localparam logic [2:0] F3_WORD = 3'd2;

    localparam alu_class_t ALU_ADDR   = 2'd0;
    localparam alu_class_t ALU_BRANCH = 2'd1;
    localparam alu_class_t ALU_FUNC   = 2'd2;

    localparam ctrl_flags_t FL_NONE     = 9'h000;
    localparam ctrl_flags_t FL_REGWRITE = 9'h001;
    localparam ctrl_flags_t FL_ALUSRC   = 9'h002;
    localparam ctrl_flags_t FL_MEMWRITE = 9'h004;
    localparam ctrl_flags_t FL_MEMREAD  = 9'h008;
    localparam ctrl_flags_t FL_MEMTOREG = 9'h010;
    localparam ctrl_flags_t FL_BRANCH   = 9'h020;
    localparam ctrl_flags_t FL_JUMP     = 9'h040;
    localparam ctrl_flags_t FL_PCTOREG  = 9'h080;
    localparam ctrl_flags_t FL_REGTOPC  = 9'h100;

    localparam mnem_t MN_NONE   = 6'd0;
    localparam mnem_t MN_LB     = 6'd1;
    localparam mnem_t MN_LH     = 6'd2;
    localparam mnem_t MN_LW     = 6'd3;
    localparam mnem_t MN_LBU    = 6'd4;
    localparam mnem_t MN_LHU    = 6'd5;
    localparam mnem_t MN_FLW    = 6'd6;
    localparam mnem_t MN_ADDI   = 6'd7;
    localparam mnem_t MN_SLLI   = 6'd8;
    localparam mnem_t MN_SLTI   = 6'd9;
    localparam mnem_t MN_SLTIU  = 6'd10;
    localparam mnem_t MN_XORI   = 6'd11;
    localparam mnem_t MN_SRLI   = 6'd12;
    localparam mnem_t MN_SRAI   = 6'd13;
    localparam mnem_t MN_ORI    = 6'd14;
    localparam mnem_t MN_ANDI   = 6'd15;
    localparam mnem_t MN_AUIPC  = 6'd16;
    localparam mnem_t MN_SB     = 6'd17;
    localparam mnem_t MN_SH     = 6'd18;
    localparam mnem_t MN_SW     = 6'd19;
    localparam mnem_t MN_FSW    = 6'd20;
    localparam mnem_t MN_ADD    = 6'd21;
    localparam mnem_t MN_SUB    = 6'd22;
    localparam mnem_t MN_SLL    = 6'd23;
    localparam mnem_t MN_SLT    = 6'd24;
    localparam mnem_t MN_SLTU   = 6'd25;
    localparam mnem_t MN_XOR    = 6'd26;
    localparam mnem_t MN_SRL    = 6'd27;
    localparam mnem_t MN_SRA    = 6'd28;
    localparam mnem_t MN_OR     = 6'd29;
    localparam mnem_t MN_AND    = 6'd30;
    localparam mnem_t MN_MUL    = 6'd31;
    localparam mnem_t MN_MULH   = 6'd32;
    localparam mnem_t MN_MULHSU = 6'd33;
    localparam mnem_t MN_MULHU  = 6'd34;
    localparam mnem_t MN_DIV    = 6'd35;
    localparam mnem_t MN_DIVU   = 6'd36;
    localparam mnem_t MN_REM    = 6'd37;
    localparam mnem_t MN_REMU   = 6'd38;
    localparam mnem_t MN_LUI    = 6'd39;
    localparam mnem_t MN_BEQ    = 6'd40;
    localparam mnem_t MN_BNE    = 6'd41;
    localparam mnem_t MN_BLT    = 6'd42;
    localparam mnem_t MN_BGE    = 6'd43;
    localparam mnem_t MN_BLTU   = 6'd44;
    localparam mnem_t MN_BGEU   = 6'd45;
    localparam mnem_t MN_JALR   = 6'd46;
    localparam mnem_t MN_JAL    = 6'd47;

    typedef struct packed {
        logic signed [31:0] imm;
        alu_class_t         alu;
        ctrl_flags_t        flags;
        mnem_t              id;
        logic               illegal;
    } dec_t;

endpackage

>>> rtl/core/rvdec_decode.sv
`timescale 1ns / 1ps

module rvdec_decode
    import rvdec_pkg::*;
(
    input  logic [31:0] word,
    output dec_t        dec
);

    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic signed [31:0] imm_i;
    logic signed [31:0] imm_s;
    logic signed [31:0] imm_b;
    logic signed [31:0] imm_u;
    logic signed [31:0] imm_j;
    logic signed [31:0] imm;
    alu_class_t         alu;
    ctrl_flags_t        flags;
    mnem_t              id;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {word[31:12], 12'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

    always_comb begin
        imm   = '0;
        alu   = ALU_ADDR;
        flags = FL_NONE;
        id    = MN_NONE;
        case (opc)
            OPC_LOAD: begin
                case (f3)
                    3'd0:    id = MN_LB;
                    3'd1:    id = MN_LH;
                    3'd2:    id = MN_LW;
                    3'd4:    id = MN_LBU;
                    3'd5:    id = MN_LHU;
                    default: id = MN_NONE;
                endcase
                imm   = imm_i;
                alu   = ALU_ADDR;
                flags = FL_REGWRITE | FL_ALUSRC | FL_MEMREAD | FL_MEMTOREG;
            end
            OPC_LOADFP: begin
                id    = (f3 == F3_WORD) ? MN_FLW : MN_NONE;
                imm   = imm_i;
                alu   = ALU_ADDR;
                flags = FL_REGWRITE | FL_ALUSRC | FL_MEMREAD | FL_MEMTOREG;
            end
            OPC_OPIMM: begin
                case (f3)
                    3'd0:    id = MN_ADDI;
                    3'd1:    id = (f7 == F7_BASE) ? MN_SLLI : MN_NONE;
                    3'd2:    id = MN_SLTI;
                    3'd3:    id = MN_SLTIU;
                    3'd4:    id = MN_XORI;
                    3'd5: begin
                        if (f7 == F7_BASE) begin
                            id = MN_SRLI;
                        end else if (f7 == F7_ALT) begin
                            id = MN_SRAI;
                        end
                    end
                    3'd6:    id = MN_ORI;
                    default: id = MN_ANDI;
                endcase
                imm   = imm_i;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE | FL_ALUSRC;
            end
            OPC_AUIPC: begin
                id    = MN_AUIPC;
                imm   = imm_u;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE | FL_ALUSRC;
            end
            OPC_STORE: begin
                case (f3)
                    3'd0:    id = MN_SB;
                    3'd1:    id = MN_SH;
                    3'd2:    id = MN_SW;
                    default: id = MN_NONE;
                endcase
                imm   = imm_s;
                alu   = ALU_ADDR;
                flags = FL_ALUSRC | FL_MEMWRITE;
            end
            OPC_STOREFP: begin
                id    = (f3 == F3_WORD) ? MN_FSW : MN_NONE;
                imm   = imm_s;
                alu   = ALU_ADDR;
                flags = FL_ALUSRC | FL_MEMWRITE;
            end
            OPC_OP: begin
                if (f7 == F7_MUL) begin
                    id = MN_MUL + mnem_t'(f3);
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0:    id = MN_ADD;
                        3'd1:    id = MN_SLL;
                        3'd2:    id = MN_SLT;
                        3'd3:    id = MN_SLTU;
                        3'd4:    id = MN_XOR;
                        3'd5:    id = MN_SRL;
                        3'd6:    id = MN_OR;
                        default: id = MN_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    case (f3)
                        3'd0:    id = MN_SUB;
                        3'd5:    id = MN_SRA;
                        default: id = MN_NONE;
                    endcase
                end
                imm   = '0;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE;
            end
            OPC_LUI: begin
                id    = MN_LUI;
                imm   = imm_u;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE | FL_ALUSRC;
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0:    id = MN_BEQ;
                    3'd1:    id = MN_BNE;
                    3'd4:    id = MN_BLT;
                    3'd5:    id = MN_BGE;
                    3'd6:    id = MN_BLTU;
                    3'd7:    id = MN_BGEU;
                    default: id = MN_NONE;
                endcase
                imm   = imm_b;
                alu   = ALU_BRANCH;
                flags = FL_BRANCH;
            end
            OPC_JALR: begin
                id    = (f3 == 3'd0) ? MN_JALR : MN_NONE;
                imm   = imm_i;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE | FL_ALUSRC | FL_JUMP | FL_PCTOREG | FL_REGTOPC;
            end
            OPC_JAL: begin
                id    = MN_JAL;
                imm   = imm_j;
                alu   = ALU_FUNC;
                flags = FL_REGWRITE | FL_ALUSRC | FL_JUMP | FL_PCTOREG;
            end
            default: begin
                id = MN_NONE;
            end
        endcase
    end

    // unrecognized words leave as bubbles
    always_comb begin
        dec.id      = id;
        dec.illegal = (id == MN_NONE);
        dec.imm     = dec.illegal ? '0 : imm;
        dec.alu     = dec.illegal ? ALU_ADDR : alu;
        dec.flags   = dec.illegal ? FL_NONE : flags;
    end

endmodule

>>> rtl/core/rv32_instruction_decoder.sv
`timescale 1ns / 1ps
// channel  | ports                                             | direction
// input    | s_valid, s_ready, s_instr_word                    | in
// result   | m_valid, m_ready, m_dest_reg .. m_illegal         | out
//
// an item moves from the input register through the decode logic into the
// result register, and m_valid rises once the item is in the result register.
// one item is accepted every cycle unless a stall fills both registers.
// synchronous active-low reset empties both registers.
// a stall on m_ready holds the result register; the input register still
// takes an item while it is empty, so ready falls only when both are full
// and m_ready is low.

module rv32_instruction_decoder
    import rvdec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_instr_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_dest_reg,
    output logic [4:0]         m_src1_reg,
    output logic [4:0]         m_src2_reg,
    output logic [2:0]         m_func3_field,
    output logic [6:0]         m_func7_field,
    output logic signed [31:0] m_immediate,
    output logic [1:0]         m_alu_class,
    output logic [8:0]         m_control_flags,
    output logic [5:0]         m_mnemonic_id,
    output logic               m_illegal
);

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        out_valid_reg;
    logic [31:7] out_word_reg;
    dec_t        out_dec_reg;
    dec_t        dec_next;
    logic        out_load;
    logic        in_load;

    rvdec_decode u_decode (
        .word (in_word_reg),
        .dec  (dec_next)
    );

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || !out_valid_reg || m_ready;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_instr_word;
        end
        if (out_load) begin
            out_word_reg <= in_word_reg[31:7];
            out_dec_reg  <= dec_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_dest_reg      = out_word_reg[11:7];
    assign m_src1_reg      = out_word_reg[19:15];
    assign m_src2_reg      = out_word_reg[24:20];
    assign m_func3_field   = out_word_reg[14:12];
    assign m_func7_field   = out_word_reg[31:25];
    assign m_immediate     = out_dec_reg.imm;
    assign m_alu_class     = out_dec_reg.alu;
    assign m_control_flags = out_dec_reg.flags;
    assign m_mnemonic_id   = out_dec_reg.id;
    assign m_illegal       = out_dec_reg.illegal;

endmodule

>>> sim/rv32_instruction_decoder_tb.sv
`timescale 1ns / 1ps

module rv32_instruction_decoder_tb
    import rvdec_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] F3_ADD      = 3'd0;
    localparam logic [2:0] F3_JALR     = 3'd0;
    localparam logic [2:0] F3_SL       = 3'd1;
    localparam logic [2:0] F3_LOAD_GAP = 3'd3;
    localparam logic [2:0] F3_SR       = 3'd5;

    // mnemonic per funct3, entry 0 rightmost
    localparam logic [7:0][5:0] LOAD_IDS =
        {MN_NONE, MN_NONE, MN_LHU, MN_LBU, MN_NONE, MN_LW, MN_LH, MN_LB};
    localparam logic [7:0][5:0] OPIMM_IDS =
        {MN_ANDI, MN_ORI, MN_SRLI, MN_XORI, MN_SLTIU, MN_SLTI, MN_SLLI, MN_ADDI};
    localparam logic [7:0][5:0] STORE_IDS =
        {MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_SW, MN_SH, MN_SB};
    localparam logic [7:0][5:0] OP_BASE_IDS =
        {MN_AND, MN_OR, MN_SRL, MN_XOR, MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
    localparam logic [7:0][5:0] OP_ALT_IDS =
        {MN_NONE, MN_NONE, MN_SRA, MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_SUB};
    localparam logic [7:0][5:0] OP_MUL_IDS =
        {MN_REMU, MN_REM, MN_DIVU, MN_DIV, MN_MULHU, MN_MULHSU, MN_MULH, MN_MUL};
    localparam logic [7:0][5:0] BRANCH_IDS =
        {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT, MN_NONE, MN_NONE, MN_BNE, MN_BEQ};
    localparam logic [10:0][6:0] KNOWN_OPCODES =
        {OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LUI, OPC_OP, OPC_STOREFP,
         OPC_STORE, OPC_AUIPC, OPC_OPIMM, OPC_LOADFP, OPC_LOAD};

    typedef struct packed {
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic signed [31:0] imm;
        alu_class_t         alu;
        ctrl_flags_t        flags;
        mnem_t              id;
        logic               illegal;
    } decoded_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_instr_word = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [4:0]         m_dest_reg;
    logic [4:0]         m_src1_reg;
    logic [4:0]         m_src2_reg;
    logic [2:0]         m_func3_field;
    logic [6:0]         m_func7_field;
    logic signed [31:0] m_immediate;
    logic [1:0]         m_alu_class;
    logic [8:0]         m_control_flags;
    logic [5:0]         m_mnemonic_id;
    logic               m_illegal;

    logic [31:0] instr_words[$];
    decoded_t    expected_decodes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_wanted = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int stall_count = 0;

    int words_pushed = 0;
    int words_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int illegal_seen = 0;
    logic [63:0] mnem_seen = '0;

    rv32_instruction_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instr_word    (s_instr_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_reg      (m_dest_reg),
        .m_src1_reg      (m_src1_reg),
        .m_src2_reg      (m_src2_reg),
        .m_func3_field   (m_func3_field),
        .m_func7_field   (m_func7_field),
        .m_immediate     (m_immediate),
        .m_alu_class     (m_alu_class),
        .m_control_flags (m_control_flags),
        .m_mnemonic_id   (m_mnemonic_id),
        .m_illegal       (m_illegal)
    );

    always #10 aclk = ~aclk;

    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t           d;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic signed [31:0] imm_i;
        logic signed [31:0] imm_s;
        logic signed [31:0] imm_b;
        logic signed [31:0] imm_u;
        logic signed [31:0] imm_j;
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_u = {w[31:12], 12'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.rd = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.f3 = f3;
        d.f7 = f7;
        d.imm = '0;
        d.alu = ALU_ADDR;
        d.flags = FL_NONE;
        d.id = MN_NONE;
        case (w[6:0])
            OPC_LOAD, OPC_LOADFP: begin
                if (w[6:0] == OPC_LOAD) d.id = LOAD_IDS[f3];
                else if (f3 == F3_WORD) d.id = MN_FLW;
                d.imm = imm_i;
                d.alu = ALU_ADDR;
                d.flags = FL_REGWRITE | FL_ALUSRC | FL_MEMREAD | FL_MEMTOREG;
            end
            OPC_OPIMM: begin
                d.id = OPIMM_IDS[f3];
                if (d.id == MN_SLLI && f7 != F7_BASE) d.id = MN_NONE;
                if (d.id == MN_SRLI) begin
                    if (f7 == F7_ALT) d.id = MN_SRAI;
                    else if (f7 != F7_BASE) d.id = MN_NONE;
                end
                d.imm = imm_i;
                d.alu = ALU_FUNC;
                d.flags = FL_REGWRITE | FL_ALUSRC;
            end
            OPC_AUIPC, OPC_LUI: begin
                d.id = (w[6:0] == OPC_LUI) ? MN_LUI : MN_AUIPC;
                d.imm = imm_u;
                d.alu = ALU_FUNC;
                d.flags = FL_REGWRITE | FL_ALUSRC;
            end
            OPC_STORE, OPC_STOREFP: begin
                if (w[6:0] == OPC_STORE) d.id = STORE_IDS[f3];
                else if (f3 == F3_WORD) d.id = MN_FSW;
                d.imm = imm_s;
                d.alu = ALU_ADDR;
                d.flags = FL_ALUSRC | FL_MEMWRITE;
            end
            OPC_OP: begin
                if (f7 == F7_MUL) d.id = OP_MUL_IDS[f3];
                else if (f7 == F7_BASE) d.id = OP_BASE_IDS[f3];
                else if (f7 == F7_ALT) d.id = OP_ALT_IDS[f3];
                d.alu = ALU_FUNC;
                d.flags = FL_REGWRITE;
            end
            OPC_BRANCH: begin
                d.id = BRANCH_IDS[f3];
                d.imm = imm_b;
                d.alu = ALU_BRANCH;
                d.flags = FL_BRANCH;
            end
            OPC_JALR: begin
                if (f3 == F3_JALR) d.id = MN_JALR;
                d.imm = imm_i;
                d.alu = ALU_FUNC;
                d.flags = FL_REGWRITE | FL_ALUSRC | FL_JUMP | FL_PCTOREG | FL_REGTOPC;
            end
            OPC_JAL: begin
                d.id = MN_JAL;
                d.imm = imm_j;
                d.alu = ALU_FUNC;
                d.flags = FL_REGWRITE | FL_ALUSRC | FL_JUMP | FL_PCTOREG;
            end
            default: begin
            end
        endcase
        // unrecognized words decode as a bubble
        if (d.id == MN_NONE) begin
            d.imm = '0;
            d.alu = ALU_ADDR;
            d.flags = FL_NONE;
        end
        d.illegal = (d.id == MN_NONE);
        return d;
    endfunction

    function automatic string decode_text(input decoded_t d);
        return {$sformatf("rd=%0d rs1=%0d rs2=%0d f3=%0d f7=%h ",
                          d.rd, d.rs1, d.rs2, d.f3, d.f7),
                $sformatf("imm=%h alu=%0d flags=%h id=%0d ill=%b",
                          d.imm, d.alu, d.flags, d.id, d.illegal)};
    endfunction

    function automatic logic [31:0] assemble(input logic [6:0] f7, input logic [4:0] rs2,
                                             input logic [4:0] rs1, input logic [2:0] f3,
                                             input logic [4:0] rd, input opcode_t opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // mostly known opcodes with funct fields steered toward defined encodings
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        opcode_t     opc;
        w = $urandom;
        if ($urandom_range(0, 15) == 0) return w;
        opc = KNOWN_OPCODES[$urandom_range(0, 10)];
        w[6:0] = opc;
        if (opc == OPC_OP || opc == OPC_OPIMM) begin
            case ($urandom_range(0, 3))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_ALT;
                2: w[31:25] = F7_MUL;
                default: begin
                end
            endcase
        end
        if ((opc == OPC_LOADFP || opc == OPC_STOREFP) && $urandom_range(0, 1) == 1)
            w[14:12] = F3_WORD;
        if (opc == OPC_JALR && $urandom_range(0, 1) == 1)
            w[14:12] = F3_JALR;
        return w;
    endfunction

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_instr_word <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_decodes.push_back(decode_word(s_instr_word));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (instr_words.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_instr_word <= instr_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_wanted && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        decoded_t got;
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            got.rd = m_dest_reg;
            got.rs1 = m_src1_reg;
            got.rs2 = m_src2_reg;
            got.f3 = m_func3_field;
            got.f7 = m_func7_field;
            got.imm = m_immediate;
            got.alu = m_alu_class;
            got.flags = m_control_flags;
            got.id = m_mnemonic_id;
            got.illegal = m_illegal;
            mnem_seen[got.id] = 1'b1;
            if (got.illegal === 1'b1) illegal_seen++;
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: %s", decode_text(got));
            end else begin
                want = expected_decodes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on item %0d", results_checked);
                        $display("  expected %s", decode_text(want));
                        $display("  actual   %s", decode_text(got));
                    end
                end
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic run_phase(input int n_random, input int idle_pct, input int stall_pct,
                             input bit long_hold);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        hold_wanted = long_hold;
        repeat (n_random) begin
            instr_words.push_back(random_word());
            words_pushed++;
        end
        while (results_checked < words_pushed) @(posedge aclk);
    endtask

    task automatic push_word(input logic [31:0] w);
        instr_words.push_back(w);
        words_pushed++;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word({20'hFFFFF, 5'd1, OPC_LUI});
        push_word({20'h80000, 5'd0, OPC_AUIPC});
        push_word({1'b1, 19'd0, 5'd1, OPC_JAL});
        push_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL});
        push_word(assemble(7'h7F, 5'h1F, 5'd3, F3_JALR, 5'd1, OPC_JALR));
        push_word(assemble(7'h00, 5'd4, 5'd3, F3_SL, 5'd1, OPC_JALR));
        push_word(assemble(7'h40, 5'd0, 5'd31, F3_WORD, 5'd0, OPC_LOAD));
        push_word(assemble(7'h00, 5'd1, 5'd2, F3_LOAD_GAP, 5'd3, OPC_LOAD));
        push_word(assemble(7'h3F, 5'h1F, 5'd1, F3_WORD, 5'd8, OPC_LOADFP));
        push_word(assemble(7'h3F, 5'h1F, 5'd1, F3_ADD, 5'd8, OPC_LOADFP));
        push_word(assemble(7'h3F, 5'd9, 5'd2, F3_WORD, 5'h1F, OPC_STORE));
        push_word(assemble(7'h40, 5'd9, 5'd2, F3_WORD, 5'h00, OPC_STOREFP));
        push_word(assemble(7'h40, 5'd9, 5'd2, F3_SL, 5'h00, OPC_STOREFP));
        push_word(assemble(7'h40, 5'd5, 5'd6, F3_ADD, 5'h00, OPC_BRANCH));
        push_word(assemble(7'h3F, 5'd5, 5'd6, F3_SL, 5'h1F, OPC_BRANCH));
        push_word(assemble(7'h00, 5'd5, 5'd6, F3_WORD, 5'h04, OPC_BRANCH));
        push_word(assemble(7'h01, 5'd3, 5'd7, F3_SL, 5'd7, OPC_OPIMM));
        push_word(assemble(F7_BASE, 5'h1F, 5'd7, F3_SR, 5'd7, OPC_OPIMM));
        push_word(assemble(F7_ALT, 5'h1F, 5'd7, F3_SR, 5'd7, OPC_OPIMM));
        push_word(assemble(7'h60, 5'd2, 5'd7, F3_SR, 5'd7, OPC_OPIMM));
        push_word(assemble(F7_ALT, 5'd10, 5'd11, F3_ADD, 5'd12, OPC_OP));
        push_word(assemble(F7_MUL, 5'd10, 5'd11, F3_SR, 5'd12, OPC_OP));
        push_word(assemble(F7_ALT, 5'd10, 5'd11, F3_SL, 5'd12, OPC_OP));
        push_word(assemble(7'h7F, 5'd10, 5'd11, F3_ADD, 5'd12, OPC_OP));
        run_phase(0, 0, 0, 1'b0);

        run_phase(280, 0, 0, 1'b0);
        run_phase(280, 65, 0, 1'b0);
        run_phase(280, 0, 65, 1'b0);
        run_phase(280, 32, 32, 1'b0);
        // long receiver hold while the sender keeps offering
        run_phase(280, 0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_decodes.size() != 0) begin
            $display("%0d expected items never arrived", expected_decodes.size());
            mismatches += expected_decodes.size();
        end
        $display("decoded %0d words (%0d illegal) across no-idle, sender-idle, receiver-stall,",
                 words_sent, illegal_seen);
        $display("mixed and long-backpressure phases; %0d of 47 mnemonics seen, %0d mismatches",
                 $countones(mnem_seen[47:1]), mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rvdec_pkg.sv
rtl/core/rvdec_decode.sv
rtl/core/rv32_instruction_decoder.sv
sim/rv32_instruction_decoder_tb.sv
